### sv/strt_pkg.sv
// ----------------------------------------------------------------------------
// strt_pkg: shared types and constants
// region record layout, item kinds, status codes and sequence compares
// ----------------------------------------------------------------------------
package strt_pkg;

  localparam int unsigned MaxRegionsDefault = 32;
  localparam int unsigned SeqW  = 32;
  localparam int unsigned TimeW = 63;
  localparam int unsigned CntW  = 8;

  // item kinds
  localparam logic [1:0] KIND_RECORD  = 2'd0;
  localparam logic [1:0] KIND_LOOKUP  = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  typedef struct packed {
    logic [CntW-1:0]  cnt;
    logic [TimeW-1:0] tl;
    logic [TimeW-1:0] tf;
    logic [SeqW-1:0]  stop;
    logic [SeqW-1:0]  start;
  } region_t;

  typedef struct packed {
    logic [SeqW-1:0]  release_seq;
    logic [SeqW-1:0]  lookup_seq;
    logic [TimeW-1:0] sent_time;
    logic [SeqW-1:0]  range_end;
    logic [SeqW-1:0]  range_begin;
    logic [1:0]       kind;
  } item_t;

  typedef struct packed {
    logic [CntW-1:0]  hit_count;
    logic [TimeW-1:0] hit_last_time;
    logic [TimeW-1:0] hit_first_time;
    logic [SeqW-1:0]  hit_end;
    logic [SeqW-1:0]  hit_begin;
    logic             found;
    logic [1:0]       status;
  } result_t;

  // modulo 2^32 compares
  function automatic logic seq_lt(logic [SeqW-1:0] a, logic [SeqW-1:0] b);
    logic [SeqW-1:0] d;
    d = a - b;
    return d[SeqW-1];
  endfunction

  function automatic logic seq_le(logic [SeqW-1:0] a, logic [SeqW-1:0] b);
    return (a == b) || seq_lt(a, b);
  endfunction

endpackage

### sv/strt_ram.sv
// ----------------------------------------------------------------------------
// strt_ram: one bank of the region table
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module strt_ram #(
  parameter int unsigned Depth = strt_pkg::MaxRegionsDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  strt_pkg::region_t     wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output strt_pkg::region_t     rdata_o
);

  strt_pkg::region_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### sv/strt_ctrl.sv
// ----------------------------------------------------------------------------
// strt_ctrl: table sequencer
// walks the live bank one entry at a time and streams the new table into
// the other bank; the banks swap when an update succeeds
// ----------------------------------------------------------------------------
module strt_ctrl #(
  parameter int unsigned MaxRegions = strt_pkg::MaxRegionsDefault,
  parameter int unsigned AddrW      = $clog2(MaxRegions),
  parameter int unsigned CntW       = $clog2(MaxRegions + 3)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  strt_pkg::item_t     in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output strt_pkg::result_t   out_res_o,
  output logic                mem_we_o,
  output logic [AddrW-1:0]    mem_waddr_o,
  output strt_pkg::region_t   mem_wdata_o,
  output logic [AddrW-1:0]    mem_raddr_o,
  input  strt_pkg::region_t   mem_rdata_i,
  output logic                bank_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PA    = 4'd1;
  localparam logic [3:0] ST_PB    = 4'd2;
  localparam logic [3:0] ST_PC    = 4'd3;
  localparam logic [3:0] ST_PREP  = 4'd4;
  localparam logic [3:0] ST_FETCH = 4'd5;
  localparam logic [3:0] ST_LOAD  = 4'd6;
  localparam logic [3:0] ST_STEP  = 4'd7;
  localparam logic [3:0] ST_TAIL  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  localparam logic [1:0] PH_PRE   = 2'd0;
  localparam logic [1:0] PH_COVER = 2'd1;
  localparam logic [1:0] PH_POST  = 2'd2;

  logic [3:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic [1:0] kind_q, kind_d;
  logic [31:0] key_q, key_d;   // range begin, lookup or release sequence
  logic [31:0] end_q, end_d;
  logic [62:0] time_q, time_d;
  logic [31:0] cur_q, cur_d;
  logic [31:0] first_q, first_d;
  strt_pkg::region_t w_q, w_d;
  logic [CntW-1:0] idx_q, idx_d, wcnt_q, wcnt_d, used_q, used_d;
  logic bank_q, bank_d, tail_q, tail_d, oval_q, oval_d;
  strt_pkg::result_t res_q, res_d;

  logic emit;
  strt_pkg::region_t emit_data, cov;
  logic [CntW-1:0] used_m1;

  // covered region merged with the new send
  always_comb begin
    cov    = w_q;
    cov.tf = (w_q.tf > time_q) ? time_q : w_q.tf;
    cov.tl = (w_q.tl < time_q) ? time_q : w_q.tl;
    cov.cnt = (w_q.cnt == 8'hFF) ? 8'hFF : w_q.cnt + 8'd1;
  end

  assign used_m1 = used_q - CntW'(1);

  always_comb begin
    state_d = state_q; phase_d = phase_q; kind_d = kind_q; key_d = key_q;
    end_d = end_q; time_d = time_q; cur_d = cur_q; first_d = first_q;
    w_d = w_q; idx_d = idx_q; wcnt_d = wcnt_q; used_d = used_q;
    bank_d = bank_q; tail_d = tail_q; oval_d = oval_q; res_d = res_q;
    emit = 1'b0;
    emit_data = w_q;
    mem_raddr_o = idx_q[AddrW-1:0];

    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !oval_q) begin
          kind_d  = in_item_i.kind;
          end_d   = in_item_i.range_end;
          time_d  = in_item_i.sent_time;
          cur_d   = in_item_i.range_begin;
          idx_d   = '0;
          wcnt_d  = '0;
          phase_d = PH_PRE;
          tail_d  = 1'b0;
          res_d   = '0;
          case (in_item_i.kind)
            strt_pkg::KIND_RECORD: begin
              key_d = in_item_i.range_begin;
              if (!strt_pkg::seq_lt(in_item_i.range_begin, in_item_i.range_end)) begin
                res_d.status = strt_pkg::STAT_BAD;
                oval_d = 1'b1;
              end else if (used_q == '0) begin
                state_d = ST_TAIL;
              end else begin
                state_d = ST_PA;
              end
            end
            strt_pkg::KIND_LOOKUP: begin
              key_d = in_item_i.lookup_seq;
              state_d = ST_FETCH;
            end
            strt_pkg::KIND_RELEASE: begin
              key_d = in_item_i.release_seq;
              state_d = ST_FETCH;
            end
            default: begin
              res_d.status = strt_pkg::STAT_BAD;
              oval_d = 1'b1;
            end
          endcase
        end
      end
      ST_PA: begin
        mem_raddr_o = '0;
        state_d = ST_PB;
      end
      ST_PB: begin
        first_d = mem_rdata_i.start;
        mem_raddr_o = used_m1[AddrW-1:0];
        state_d = ST_PC;
      end
      ST_PC: begin
        if (!(strt_pkg::seq_le(first_q, key_q) &&
              strt_pkg::seq_le(key_q, mem_rdata_i.stop))) begin
          res_d.status = strt_pkg::STAT_BAD;
          oval_d = 1'b1;
          state_d = ST_IDLE;
        end else if (mem_rdata_i.stop == key_q) begin
          phase_d = PH_POST;
          tail_d  = 1'b1;
          state_d = ST_FETCH;
        end else if (end_q == first_q) begin
          state_d = ST_PREP;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_PREP: begin
        emit = 1'b1;
        emit_data = '{cnt: 8'd1, tl: time_q, tf: time_q, stop: end_q, start: key_q};
        phase_d = PH_POST;
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        if (idx_q == used_q) begin
          if (kind_q == strt_pkg::KIND_RECORD) begin
            if (phase_q == PH_PRE) begin
              res_d.status = strt_pkg::STAT_BAD;
              oval_d = 1'b1;
              state_d = ST_IDLE;
            end else if (tail_q || (phase_q == PH_COVER && cur_q != end_q)) begin
              state_d = ST_TAIL;
            end else begin
              state_d = ST_FIN;
            end
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        w_d = mem_rdata_i;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        case (kind_q)
          strt_pkg::KIND_LOOKUP: begin
            if (strt_pkg::seq_lt(key_q, w_q.start)) begin
              oval_d = 1'b1;
              state_d = ST_IDLE;
            end else if (strt_pkg::seq_lt(key_q, w_q.stop)) begin
              res_d.found          = 1'b1;
              res_d.hit_begin      = w_q.start;
              res_d.hit_end        = w_q.stop;
              res_d.hit_first_time = w_q.tf;
              res_d.hit_last_time  = w_q.tl;
              res_d.hit_count      = w_q.cnt;
              oval_d = 1'b1;
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q + CntW'(1);
              state_d = ST_FETCH;
            end
          end
          strt_pkg::KIND_RELEASE: begin
            idx_d = idx_q + CntW'(1);
            state_d = ST_FETCH;
            if (phase_q == PH_PRE && strt_pkg::seq_le(w_q.stop, key_q)) begin
              // dropped region
            end else begin
              emit = 1'b1;
              if (phase_q == PH_PRE && strt_pkg::seq_lt(w_q.start, key_q)) begin
                emit_data.start = key_q;
              end
              phase_d = PH_POST;
            end
          end
          default: begin
            unique case (phase_q)
              PH_PRE: begin
                if (strt_pkg::seq_le(w_q.stop, key_q)) begin
                  emit = 1'b1;
                  idx_d = idx_q + CntW'(1);
                  state_d = ST_FETCH;
                end else if (!strt_pkg::seq_le(w_q.start, key_q)) begin
                  res_d.status = strt_pkg::STAT_BAD;
                  oval_d = 1'b1;
                  state_d = ST_IDLE;
                end else begin
                  if (w_q.start != key_q) begin
                    // split off the part below the range
                    emit = 1'b1;
                    emit_data.stop = key_q;
                    w_d.start = key_q;
                  end
                  phase_d = PH_COVER;
                end
              end
              PH_COVER: begin
                if (strt_pkg::seq_le(w_q.stop, end_q)) begin
                  if (w_q.start != cur_q) begin
                    res_d.status = strt_pkg::STAT_BAD;
                    oval_d = 1'b1;
                    state_d = ST_IDLE;
                  end else begin
                    emit = 1'b1;
                    emit_data = cov;
                    cur_d = w_q.stop;
                    idx_d = idx_q + CntW'(1);
                    state_d = ST_FETCH;
                  end
                end else if (cur_q != end_q) begin
                  if (w_q.start != cur_q) begin
                    res_d.status = strt_pkg::STAT_BAD;
                    oval_d = 1'b1;
                    state_d = ST_IDLE;
                  end else begin
                    // covered head of a region that reaches past the range
                    emit = 1'b1;
                    emit_data = cov;
                    emit_data.stop = end_q;
                    w_d.start = end_q;
                    phase_d = PH_POST;
                  end
                end else begin
                  phase_d = PH_POST;
                end
              end
              default: begin
                emit = 1'b1;
                idx_d = idx_q + CntW'(1);
                state_d = ST_FETCH;
              end
            endcase
          end
        endcase
      end
      ST_TAIL: begin
        emit = 1'b1;
        emit_data = '{cnt: 8'd1, tl: time_q, tf: time_q, stop: end_q, start: cur_q};
        state_d = ST_FIN;
      end
      ST_FIN: begin
        oval_d = 1'b1;
        state_d = ST_IDLE;
        if (kind_q == strt_pkg::KIND_RECORD && wcnt_q > CntW'(MaxRegions)) begin
          res_d.status = strt_pkg::STAT_FULL;
        end else if (kind_q != strt_pkg::KIND_LOOKUP) begin
          bank_d = ~bank_q;
          used_d = wcnt_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit) begin
      wcnt_d = wcnt_q + CntW'(1);
    end
  end

  assign mem_we_o    = emit && (wcnt_q < CntW'(MaxRegions));
  assign mem_waddr_o = wcnt_q[AddrW-1:0];
  assign mem_wdata_o = emit_data;
  assign in_ready_o  = (state_q == ST_IDLE) && !oval_q;
  assign out_valid_o = oval_q;
  assign out_res_o   = res_q;
  assign bank_o      = bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_PRE;
      idx_q   <= '0;
      wcnt_q  <= '0;
      used_q  <= '0;
      bank_q  <= 1'b0;
      tail_q  <= 1'b0;
      oval_q  <= 1'b0;
      kind_q  <= strt_pkg::KIND_RECORD;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      wcnt_q  <= wcnt_d;
      used_q  <= used_d;
      bank_q  <= bank_d;
      tail_q  <= tail_d;
      oval_q  <= oval_d;
      kind_q  <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    end_q   <= end_d;
    time_q  <= time_d;
    cur_q   <= cur_d;
    first_q <= first_d;
    w_q     <= w_d;
    res_q   <= res_d;
  end

endmodule

### sv/segment_transmit_region_table.sv
// ----------------------------------------------------------------------------
// segment_transmit_region_table: ordered table of sent sequence regions
// record, lookup and release of contiguous sequence ranges with send times
// ----------------------------------------------------------------------------
// usage
//   slave channel: one word per command; tuser carries the kind (record send,
//   lookup, release), tdata the range, send time and sequence numbers
//   master channel: one result word per command; tuser carries the status,
//   tdata the lookup hit flag and the region found (zero otherwise)
// command flow
//   one command at a time; the sequencer walks the table one entry at a
//   time (read, load, step) plus a step for each extra region it writes;
//   the default full table holds 32 regions
//   the walk is paced by the single read port of the table bank
// structure
//   two table banks: the walk reads the live bank and writes the updated
//   table into the spare bank, which becomes live when the update succeeds;
//   errors and overflow leave the live bank untouched
// reset
//   the table comes up empty; bank contents need no clearing
// stalls
//   the result stays in the output register until m_axis_tready; no new
//   command is taken while it waits
// ----------------------------------------------------------------------------
module segment_transmit_region_table #(
  parameter int unsigned MAX_REGIONS = strt_pkg::MaxRegionsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // range_begin, range_end, sent_time, lookup_seq, release_seq, zero pad
  input  logic [191:0] s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found, hit_begin, hit_end, hit_first_time, hit_last_time, hit_count, pad
  output logic [199:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned AddrW = $clog2(MAX_REGIONS);
  localparam int unsigned CntW  = $clog2(MAX_REGIONS + 3);

  strt_pkg::item_t   item;
  strt_pkg::result_t res;
  strt_pkg::region_t wdata, rdata0, rdata1, rdata;
  logic              we, bank;
  logic [AddrW-1:0]  waddr, raddr;

  // unpack the command word
  assign item.kind        = s_axis_tuser;
  assign item.range_begin = s_axis_tdata[31:0];
  assign item.range_end   = s_axis_tdata[63:32];
  assign item.sent_time   = s_axis_tdata[126:64];
  assign item.lookup_seq  = s_axis_tdata[158:127];
  assign item.release_seq = s_axis_tdata[190:159];

  strt_ctrl #(
    .MaxRegions (MAX_REGIONS),
    .AddrW      (AddrW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .mem_we_o    (we),
    .mem_waddr_o (waddr),
    .mem_wdata_o (wdata),
    .mem_raddr_o (raddr),
    .mem_rdata_i (rdata),
    .bank_o      (bank)
  );

  // the spare bank takes the writes, the live bank serves the reads
  strt_ram #(.Depth(MAX_REGIONS), .AddrW(AddrW)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we && bank),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata0)
  );

  strt_ram #(.Depth(MAX_REGIONS), .AddrW(AddrW)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we && !bank),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata1)
  );

  assign rdata = bank ? rdata1 : rdata0;

  // pack the result word
  assign m_axis_tuser          = res.status;
  assign m_axis_tdata[0]       = res.found;
  assign m_axis_tdata[32:1]    = res.hit_begin;
  assign m_axis_tdata[64:33]   = res.hit_end;
  assign m_axis_tdata[127:65]  = res.hit_first_time;
  assign m_axis_tdata[190:128] = res.hit_last_time;
  assign m_axis_tdata[198:191] = res.hit_count;
  assign m_axis_tdata[199]     = 1'b0;

endmodule

### tb/segment_transmit_region_table_checker.sv
// ----------------------------------------------------------------------------
// segment_transmit_region_table_checker: result predictor and comparator
// watches both streams, keeps its own region table, predicts each result word
// and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module segment_transmit_region_table_checker #(
  parameter int unsigned MAX_REGIONS = strt_pkg::MaxRegionsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [199:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o,
  output int unsigned  hits_o,
  output int unsigned  full_o,
  output int unsigned  bad_o
);

  localparam int unsigned WorkDepth = MAX_REGIONS + 2;
  localparam int unsigned DueDepth  = 16;

  strt_pkg::region_t table_q[MAX_REGIONS];
  int unsigned       used_q;
  strt_pkg::region_t work[WorkDepth];

  // predicted result words waiting for the block, oldest at due_rd
  strt_pkg::result_t due_q[DueDepth];
  int unsigned       due_rd;
  int unsigned       due_wr;
  int unsigned       due_cnt;

  function automatic logic precedes(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic not_after(logic [31:0] a, logic [31:0] b);
    return (a == b) || precedes(a, b);
  endfunction

  function automatic logic [7:0] bump(logic [7:0] c);
    return (c == 8'd255) ? c : c + 8'd1;
  endfunction

  function automatic void splice(inout int unsigned n, input int unsigned pos,
                                 input strt_pkg::region_t s);
    if (n >= WorkDepth || pos > n) return;
    for (int k = int'(n); k > int'(pos); k--) work[k] = work[k-1];
    work[pos] = s;
    n++;
  endfunction

  // marks [b, e) as sent at t; returns the status code
  function automatic logic [1:0] mark_sent(logic [31:0] b, logic [31:0] e,
                                           logic [62:0] t);
    int unsigned       n;
    int unsigned       i;
    strt_pkg::region_t s;
    strt_pkg::region_t lo;
    logic [31:0]       cur;
    n = used_q;
    cur = b;
    if (!precedes(b, e)) return strt_pkg::STAT_BAD;
    for (i = 0; i < n; i++) work[i] = table_q[i];
    if (n > 0 && !(not_after(work[0].start, b) && not_after(b, work[n-1].stop)))
      return strt_pkg::STAT_BAD;
    s.start = b; s.stop = e; s.tf = t; s.tl = t; s.cnt = 8'd1;
    if (n == 0 || work[n-1].stop == b) begin
      splice(n, n, s);
    end else if (e == work[0].start) begin
      splice(n, 0, s);
    end else begin
      i = 0;
      while (i < n && not_after(work[i].stop, cur)) i++;
      if (i >= n || !not_after(work[i].start, cur)) return strt_pkg::STAT_BAD;
      if (cur != work[i].start) begin
        lo = work[i];
        lo.stop = cur;
        splice(n, i, lo);
        i++;
        work[i].start = cur;
      end
      while (i < n && not_after(work[i].stop, e)) begin
        if (work[i].start != cur) return strt_pkg::STAT_BAD;
        if (work[i].tf > t) work[i].tf = t;
        if (work[i].tl < t) work[i].tl = t;
        work[i].cnt = bump(work[i].cnt);
        cur = work[i].stop;
        i++;
      end
      if (cur != e) begin
        if (i < n) begin
          if (work[i].start != cur) return strt_pkg::STAT_BAD;
          s.start = cur;
          s.stop = e;
          s.tf = (work[i].tf < t) ? work[i].tf : t;
          s.tl = (work[i].tl > t) ? work[i].tl : t;
          s.cnt = bump(work[i].cnt);
          splice(n, i, s);
          work[i+1].start = e;
        end else begin
          s.start = cur;
          splice(n, n, s);
        end
      end
    end
    if (n > MAX_REGIONS) return strt_pkg::STAT_FULL;
    for (i = 0; i < n; i++) table_q[i] = work[i];
    used_q = n;
    return strt_pkg::STAT_OK;
  endfunction

  function automatic void release_below(logic [31:0] seq);
    int unsigned drop;
    drop = 0;
    while (drop < used_q && not_after(table_q[drop].stop, seq)) drop++;
    for (int unsigned i = drop; i < used_q; i++) table_q[i-drop] = table_q[i];
    used_q -= drop;
    if (used_q > 0 && precedes(table_q[0].start, seq)) table_q[0].start = seq;
  endfunction

  function automatic strt_pkg::result_t predict_word(logic [1:0] kind,
                                                     logic [191:0] d);
    strt_pkg::result_t r;
    r = '0;
    case (kind)
      strt_pkg::KIND_RECORD: begin
        r.status = mark_sent(d[31:0], d[63:32], d[126:64]);
      end
      strt_pkg::KIND_LOOKUP: begin
        for (int unsigned i = 0; i < used_q; i++) begin
          if (precedes(d[158:127], table_q[i].start)) break;
          if (precedes(d[158:127], table_q[i].stop)) begin
            r.found          = 1'b1;
            r.hit_begin      = table_q[i].start;
            r.hit_end        = table_q[i].stop;
            r.hit_first_time = table_q[i].tf;
            r.hit_last_time  = table_q[i].tl;
            r.hit_count      = table_q[i].cnt;
            break;
          end
        end
      end
      strt_pkg::KIND_RELEASE: begin
        release_below(d[190:159]);
      end
      default: r.status = strt_pkg::STAT_BAD;
    endcase
    return r;
  endfunction

  task automatic compare_word(strt_pkg::result_t x, strt_pkg::result_t a);
    if (a.status !== x.status) begin
      $error("status: expected %0d, got %0d", x.status, a.status);
      fail_count_o++;
    end
    if (a.found !== x.found) begin
      $error("found: expected %0d, got %0d", x.found, a.found);
      fail_count_o++;
    end
    if (a.hit_begin !== x.hit_begin) begin
      $error("hit_begin: expected %h, got %h", x.hit_begin, a.hit_begin);
      fail_count_o++;
    end
    if (a.hit_end !== x.hit_end) begin
      $error("hit_end: expected %h, got %h", x.hit_end, a.hit_end);
      fail_count_o++;
    end
    if (a.hit_first_time !== x.hit_first_time) begin
      $error("hit_first_time: expected %h, got %h", x.hit_first_time, a.hit_first_time);
      fail_count_o++;
    end
    if (a.hit_last_time !== x.hit_last_time) begin
      $error("hit_last_time: expected %h, got %h", x.hit_last_time, a.hit_last_time);
      fail_count_o++;
    end
    if (a.hit_count !== x.hit_count) begin
      $error("hit_count: expected %0d, got %0d", x.hit_count, a.hit_count);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    strt_pkg::result_t got;
    strt_pkg::result_t want;
    if (!rst_ni) begin
      used_q = 0;
      due_rd = 0;
      due_wr = 0;
      due_cnt = 0;
      fail_count_o = 0;
      hits_o = 0;
      full_o = 0;
      bad_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status         = m_axis_tuser;
        got.found          = m_axis_tdata[0];
        got.hit_begin      = m_axis_tdata[32:1];
        got.hit_end        = m_axis_tdata[64:33];
        got.hit_first_time = m_axis_tdata[127:65];
        got.hit_last_time  = m_axis_tdata[190:128];
        got.hit_count      = m_axis_tdata[198:191];
        if (due_cnt == 0) begin
          $error("result word with nothing expected");
          fail_count_o++;
        end else begin
          want = due_q[due_rd];
          due_rd = (due_rd + 1) % DueDepth;
          due_cnt--;
          compare_word(want, got);
          if (want.found) hits_o++;
          if (want.status == strt_pkg::STAT_FULL) full_o++;
          if (want.status == strt_pkg::STAT_BAD) bad_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (due_cnt == DueDepth) begin
          $error("too many words in flight");
          fail_count_o++;
        end else begin
          due_q[due_wr] = predict_word(s_axis_tuser, s_axis_tdata);
          due_wr = (due_wr + 1) % DueDepth;
          due_cnt++;
        end
      end
    end
    pending_o = due_cnt;
  end

endmodule

### tb/segment_transmit_region_table_test.sv
// ----------------------------------------------------------------------------
// segment_transmit_region_table_test: stimulus and verdict
// drives record, lookup, release and unused-kind words with bursty timing against a
// stalling receiver; the checker predicts and compares every result word
// ----------------------------------------------------------------------------
module segment_transmit_region_table_test;

  // kind code with no operation behind it
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // range_begin, range_end, sent_time, lookup_seq, release_seq, zero pad
  logic [191:0] s_axis_tdata;
  // kind
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // found, hit_begin, hit_end, hit_first_time, hit_last_time, hit_count, pad
  logic [199:0] m_axis_tdata;
  // status
  logic [1:0]   m_axis_tuser;

  int unsigned  fail_count;
  int unsigned  pending;
  int unsigned  hits;
  int unsigned  fulls;
  int unsigned  bads;

  // receiver hold-off request, served by its own process
  logic         hold_off;
  int unsigned  burst_left;
  int unsigned  words_sent;

  // rough shadow of the table span, used only to aim ranges
  logic [31:0]  span_lo;
  logic [31:0]  span_hi;
  logic         span_live;

  segment_transmit_region_table i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  segment_transmit_region_table_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .hits_o       (hits),
    .full_o       (fulls),
    .bad_o        (bads)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // generous run limit
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: stall mode rotates through always ready, mostly ready and mostly stalled; hold-off overrides it
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned cyc;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      cyc = 0;
    end else begin
      cyc++;
      case ((cyc / 64) % 3)
        0:       m_axis_tready <= !hold_off;
        1:       m_axis_tready <= !hold_off && ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= !hold_off && ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // one word on the slave channel, with bursts and gaps between them
  task automatic push_word(input logic [1:0] kind, input logic [31:0] rb,
                           input logic [31:0] re, input logic [62:0] st,
                           input logic [31:0] ls, input logic [31:0] rs);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, rs, ls, st, re, rb};
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    @(posedge clk_i);
    words_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [62:0] any_time();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic logic precedes_tb(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  // a record aimed at the table: append, overlap, prepend or a fresh start
  task automatic aimed_record();
    logic [31:0] b;
    logic [31:0] e;
    int unsigned pick;
    int unsigned width;
    pick = $urandom_range(0, 99);
    width = span_hi - span_lo;
    if (!span_live) begin
      b = $urandom;
      e = b + $urandom_range(1, 64);
      span_lo = b; span_hi = e; span_live = 1'b1;
    end else if (pick < 40) begin
      b = span_hi;
      e = b + $urandom_range(1, 64);
      span_hi = e;
    end else if (pick < 85 && width > 0) begin
      b = span_lo + $urandom_range(0, (width > 4000) ? 4000 : width - 1);
      e = b + $urandom_range(1, 96);
      if (precedes_tb(span_hi, e)) span_hi = e;
    end else begin
      e = span_lo;
      b = e - $urandom_range(1, 64);
      span_lo = b;
    end
    push_word(strt_pkg::KIND_RECORD, b, e, any_time(), $urandom, $urandom);
  endtask

  task automatic aimed_release();
    logic [31:0] seq;
    int unsigned width;
    width = span_hi - span_lo;
    seq = span_lo + $urandom_range(0, ((width > 4000) ? 4000 : width) + 8);
    if (!precedes_tb(seq, span_hi)) span_live = 1'b0;
    else if (precedes_tb(span_lo, seq)) span_lo = seq;
    push_word(strt_pkg::KIND_RELEASE, $urandom, $urandom, any_time(), $urandom, seq);
  endtask

  task automatic aimed_lookup();
    logic [31:0] seq;
    seq = span_lo + $urandom_range(0, (span_hi - span_lo > 4000) ? 4000 :
                                   span_hi - span_lo) - 2;
    push_word(strt_pkg::KIND_LOOKUP, $urandom, $urandom, any_time(), seq, $urandom);
  endtask

  initial begin
    logic [62:0] tmax;
    tmax = '1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = strt_pkg::KIND_RECORD;
    hold_off      = 1'b0;
    burst_left    = 3;
    words_sent    = 0;
    span_live     = 1'b0;
    span_lo       = '0;
    span_hi       = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: misuse on an empty table
    push_word(KIND_SPARE, '0, '0, '0, '0, '0);
    push_word(strt_pkg::KIND_RELEASE, '0, '0, '0, '0, 32'h1234);
    push_word(strt_pkg::KIND_LOOKUP, '0, '0, '0, 32'h0, '0);
    push_word(strt_pkg::KIND_RECORD, 32'h10, 32'h10, '0, '0, '0);   // empty range
    push_word(strt_pkg::KIND_RECORD, 32'h20, 32'h10, '0, '0, '0);   // reversed range
    // range straddling the wrap of the sequence space
    push_word(strt_pkg::KIND_RECORD, 32'hFFFF_FFF0, 32'h10, 63'd5, '0, '0);
    push_word(strt_pkg::KIND_RECORD, 32'h10, 32'h30, tmax, '0, '0);  // append
    // prepend
    push_word(strt_pkg::KIND_RECORD, 32'hFFFF_FFE0, 32'hFFFF_FFF0, '0, '0, '0);
    // split both
    push_word(strt_pkg::KIND_RECORD, 32'hFFFF_FFF8, 32'h20, 63'd7, '0, '0);
    // outside
    push_word(strt_pkg::KIND_RECORD, 32'h8000_0000, 32'h8000_0010, '0, '0, '0);
    // before first
    push_word(strt_pkg::KIND_RECORD, 32'hFFFF_FF00, 32'hFFFF_FFE8, '0, '0, '0);
    // overlap past end
    push_word(strt_pkg::KIND_RECORD, 32'h28, 32'h40, 63'd3, '0, '0);
    push_word(strt_pkg::KIND_LOOKUP, '0, '0, '0, 32'hFFFF_FFFF, '0);
    push_word(strt_pkg::KIND_LOOKUP, '0, '0, '0, 32'h2F, '0);
    push_word(strt_pkg::KIND_LOOKUP, '0, '0, '0, 32'h40, '0);       // just past end
    push_word(strt_pkg::KIND_LOOKUP, '0, '0, '0, 32'h7FFF_FFFF, '0);
    push_word(strt_pkg::KIND_RELEASE, '0, '0, '0, '0, 32'hFFFF_FFF4); // trim first
    push_word(strt_pkg::KIND_LOOKUP, '0, '0, '0, 32'hFFFF_FFF4, '0);
    push_word(strt_pkg::KIND_RELEASE, '0, '0, '0, '0, 32'h40);      // release all
    push_word(strt_pkg::KIND_LOOKUP, '0, '0, '0, 32'h3F, '0);

    // count saturation on one region
    for (int k = 0; k < 258; k++)
      push_word(strt_pkg::KIND_RECORD, 32'hA000_0000, 32'hA000_0004, 63'(k), '0, '0);
    push_word(strt_pkg::KIND_LOOKUP, '0, '0, '0, 32'hA000_0002, '0);
    push_word(strt_pkg::KIND_RELEASE, '0, '0, '0, '0, 32'hA000_0004);

    // long receiver hold-off while the sender keeps offering words
    fork
      begin
        hold_off <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none

    // random: mostly aimed sequences, some noise
    for (int k = 0; k < 280; k++) begin
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)      aimed_record();
      else if (pick < 80) aimed_lookup();
      else if (pick < 92) aimed_release();
      else push_word(2'($urandom_range(0, 3)), $urandom, $urandom, any_time(),
                     $urandom, $urandom);
    end
    s_axis_tvalid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (120) @(posedge clk_i);

    $display("covered %0d words: %0d lookup hits, %0d table-full, %0d rejected",
             words_sent, hits, fulls, bads);
    $display("including wrap-around ranges, count saturation and a long output stall");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
